// File: rtl/acc_pkg.sv
`default_nettype none
package acc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PeriodW-1:0] BeepPeriodRst   = 16'd270;
  localparam logic [PeriodW-1:0] HeartbeatOnRst  = 16'd50;
  localparam logic [PeriodW-1:0] HeartbeatOffRst = 16'd950;

  localparam logic [CfgIdxW-1:0] RegBeepPeriod   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeartbeatOn  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeartbeatOff = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } acc_kind_e;

  typedef struct packed {
    logic [PeriodW-1:0] beep_period_ms;
    logic [PeriodW-1:0] heartbeat_on_ms;
    logic [PeriodW-1:0] heartbeat_off_ms;
  } acc_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             link_up;
    logic             button_cancel;
    logic [1:0]       packet_kind;
    logic [TimeW-1:0] packet_stamp;
  } acc_item_t;

  typedef struct packed {
    logic             armed;
    logic             cancel_pending;
    logic [TimeW-1:0] last_stamp;
    logic [TimeW-1:0] beep_mark;
    logic [TimeW-1:0] beat_mark;
    logic             beep_phase;
    logic             sounding;
    logic             red_level;
    logic             green_level;
  } acc_state_t;

  typedef struct packed {
    logic request_reconnect;
    logic report_stop;
    logic buzzer_on;
    logic green_led;
    logic red_led;
  } acc_result_t;

endpackage
`default_nettype wire

// File: rtl/acc_pass.sv
`default_nettype none
module acc_pass (
  input  acc_pkg::acc_cfg_t    cfg_i,
  input  acc_pkg::acc_state_t  state_i,
  input  acc_pkg::acc_item_t   item_i,
  output acc_pkg::acc_state_t  state_o,
  output acc_pkg::acc_result_t result_o
);
  import acc_pkg::*;

  logic [TimeW-1:0] beat_elapsed;
  logic [TimeW-1:0] beep_elapsed;
  logic [TimeW-1:0] beep_mark_mid;
  logic [PeriodW-1:0] beat_wait;
  logic start_ok;
  logic armed_mid;
  logic cancel_mid;
  logic report;

  assign beat_elapsed = item_i.now_ms - state_i.beat_mark;
  assign beat_wait    = state_i.green_level ? cfg_i.heartbeat_on_ms : cfg_i.heartbeat_off_ms;
  assign start_ok     = (item_i.packet_kind == KIND_START) &&
                        (item_i.packet_stamp > state_i.last_stamp);
  assign beep_mark_mid = start_ok ? item_i.now_ms : state_i.beep_mark;
  assign armed_mid     = start_ok | state_i.armed;
  assign cancel_mid    = (item_i.packet_kind == KIND_STOP) |
                         (~start_ok & (state_i.cancel_pending | item_i.button_cancel));
  assign beep_elapsed  = item_i.now_ms - beep_mark_mid;

  always_comb begin
    state_o = state_i;
    report  = 1'b0;
    state_o.cancel_pending = state_i.cancel_pending | item_i.button_cancel;
    if (!item_i.link_up) begin
      state_o.red_level   = 1'b1;
      state_o.green_level = 1'b0;
    end else begin
      if (!state_i.armed) begin
        state_o.red_level = 1'b0;
        if (beat_elapsed >= {{(TimeW-PeriodW){1'b0}}, beat_wait}) begin
          state_o.beat_mark   = item_i.now_ms;
          state_o.green_level = ~state_i.green_level;
        end
      end
      if (start_ok) begin
        state_o.last_stamp  = item_i.packet_stamp;
        state_o.red_level   = 1'b1;
        state_o.green_level = 1'b0;
      end
      state_o.armed          = armed_mid;
      state_o.cancel_pending = cancel_mid;
      state_o.beep_mark      = beep_mark_mid;
      if (armed_mid) begin
        if (beep_elapsed >= {{(TimeW-PeriodW){1'b0}}, cfg_i.beep_period_ms}) begin
          state_o.beep_phase = ~state_i.beep_phase;
          state_o.sounding   = ~state_i.beep_phase;
          state_o.beep_mark  = item_i.now_ms;
        end
        if (cancel_mid) begin
          state_o.sounding       = 1'b0;
          state_o.red_level      = 1'b0;
          state_o.green_level    = 1'b0;
          state_o.armed          = 1'b0;
          state_o.cancel_pending = 1'b0;
          report                 = 1'b1;
        end
      end
    end
  end

  assign result_o.red_led           = state_o.red_level;
  assign result_o.green_led         = state_o.green_level;
  assign result_o.buzzer_on         = state_o.sounding;
  assign result_o.report_stop       = report;
  assign result_o.request_reconnect = ~item_i.link_up;

endmodule
`default_nettype wire

// File: rtl/alarm_annunciator_control.sv
`default_nettype none
// Alarm annunciator control. One slave transaction is one control pass and
// yields exactly one master transaction holding the LED, buzzer and pulse
// levels after that pass. The block takes one transaction per clock: a pass
// is registered on entry, evaluated combinationally against the stored
// state, and its result held in an output register; a stalled master
// side only stops the input once both registers
// are full. Configuration writes are taken every cycle and should only be
// issued while no pass is in flight; writes to an unused index are dropped.
module alarm_annunciator_control (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] now_ms, [32] link_up, [33] button_cancel, [65:34] packet_stamp, [71:66] zero
  input  wire logic [71:0] s_axis_tdata,
  // [1:0] packet_kind
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] red_led, [1] green_led, [2] buzzer_on, [3] report_stop,
  // [4] request_reconnect, [7:5] zero
  output logic [7:0]       m_axis_tdata
);
  import acc_pkg::*;

  acc_cfg_t    cfg_q;
  acc_state_t  state_q, state_d;
  acc_item_t   item_q;
  acc_result_t result_d, result_q;
  logic        item_valid_q;
  logic        advance;

  assign cfg_ready_o   = 1'b1;
  assign advance       = item_valid_q & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~item_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beep_period_ms   <= BeepPeriodRst;
      cfg_q.heartbeat_on_ms  <= HeartbeatOnRst;
      cfg_q.heartbeat_off_ms <= HeartbeatOffRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBeepPeriod:   cfg_q.beep_period_ms   <= cfg_data_i;
        RegHeartbeatOn:  cfg_q.heartbeat_on_ms  <= cfg_data_i;
        RegHeartbeatOff: cfg_q.heartbeat_off_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.now_ms        <= s_axis_tdata[31:0];
      item_q.link_up       <= s_axis_tdata[32];
      item_q.button_cancel <= s_axis_tdata[33];
      item_q.packet_stamp  <= s_axis_tdata[65:34];
      item_q.packet_kind   <= s_axis_tuser;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q  <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state_q       <= '{armed: 1'b0, cancel_pending: 1'b0, last_stamp: '0,
                         beep_mark: '0, beat_mark: '0, beep_phase: 1'b0,
                         sounding: 1'b0, red_level: 1'b1, green_level: 1'b0};
    end else begin
      if (s_axis_tready) begin
        item_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q       <= state_d;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  acc_pass u_pass (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  assign m_axis_tdata = {3'b000, result_q};

endmodule
`default_nettype wire

// File: rtl/acc_checker.sv
`default_nettype none
module acc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);

  // stalled result transaction must hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // link down forces red on, green off and no stop report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0] && !m_axis_tdata[1] &&
      !m_axis_tdata[3])
    else $error("reconnect pass with wrong LED or report levels");

  // a stop report clears all indicators
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[0] && !m_axis_tdata[1] &&
      !m_axis_tdata[2] && !m_axis_tdata[4])
    else $error("stop report with indicators still on");

  // buzzer only sounds while armed, which shows red and no heartbeat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2] || m_axis_tdata[1]) |->
      (m_axis_tdata[2] && m_axis_tdata[0] && !m_axis_tdata[1]) ||
      (!m_axis_tdata[2] && !m_axis_tdata[0]))
    else $error("buzzer or heartbeat with inconsistent LEDs");

endmodule

bind alarm_annunciator_control acc_checker u_acc_checker (.*);
`default_nettype wire

// File: tb/alarm_annunciator_control_tb.sv
module alarm_annunciator_control_tb;
  import acc_pkg::*;

  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 80;
  localparam logic [1:0]  KindUnused   = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  acc_state_t  alarm_state;
  acc_cfg_t    alarm_cfg;
  acc_result_t pass_results_q[$];
  logic [31:0] clock_ms = 32'h0000_0200;
  int          send_idle_pct = 9;
  int          recv_idle_pct = 88;
  int          mismatches = 0;
  logic        rx_hold = 1'b0;
  event        hold_rx;

  alarm_annunciator_control dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one control pass: updates the alarm state and returns the output levels
  function automatic acc_result_t run_control_pass(acc_item_t p);
    acc_result_t r;
    logic [31:0] elapsed;
    logic [15:0] dwell;
    r = '0;
    if (p.button_cancel) alarm_state.cancel_pending = 1'b1;
    if (!p.link_up) begin
      alarm_state.red_level   = 1'b1;
      alarm_state.green_level = 1'b0;
      r.request_reconnect     = 1'b1;
    end else begin
      if (!alarm_state.armed) begin
        alarm_state.red_level = 1'b0;
        dwell = alarm_state.green_level ? alarm_cfg.heartbeat_on_ms
                                        : alarm_cfg.heartbeat_off_ms;
        elapsed = p.now_ms - alarm_state.beat_mark;
        if (elapsed >= {16'd0, dwell}) begin
          alarm_state.beat_mark   = p.now_ms;
          alarm_state.green_level = !alarm_state.green_level;
        end
      end
      if (p.packet_kind == KIND_START && p.packet_stamp > alarm_state.last_stamp) begin
        alarm_state.last_stamp     = p.packet_stamp;
        alarm_state.red_level      = 1'b1;
        alarm_state.green_level    = 1'b0;
        alarm_state.beep_mark      = p.now_ms;
        alarm_state.armed          = 1'b1;
        alarm_state.cancel_pending = 1'b0;
      end
      if (p.packet_kind == KIND_STOP) alarm_state.cancel_pending = 1'b1;
      if (alarm_state.armed) begin
        elapsed = p.now_ms - alarm_state.beep_mark;
        if (elapsed >= {16'd0, alarm_cfg.beep_period_ms}) begin
          alarm_state.beep_phase = !alarm_state.beep_phase;
          alarm_state.sounding   = alarm_state.beep_phase;
          alarm_state.beep_mark  = p.now_ms;
        end
        if (alarm_state.cancel_pending) begin
          alarm_state.sounding       = 1'b0;
          alarm_state.red_level      = 1'b0;
          alarm_state.green_level    = 1'b0;
          alarm_state.armed          = 1'b0;
          alarm_state.cancel_pending = 1'b0;
          r.report_stop              = 1'b1;
        end
      end
    end
    r.red_led   = alarm_state.red_level;
    r.green_led = alarm_state.green_level;
    r.buzzer_on = alarm_state.sounding;
    return r;
  endfunction

  function automatic acc_item_t pass_of(logic [31:0] now, logic link, logic btn,
                                        logic [1:0] kind, logic [31:0] stamp);
    acc_item_t p;
    p.now_ms        = now;
    p.link_up       = link;
    p.button_cancel = btn;
    p.packet_kind   = kind;
    p.packet_stamp  = stamp;
    return p;
  endfunction

  task automatic send_pass(input acc_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, p.packet_stamp, p.button_cancel, p.link_up, p.now_ms};
    s_axis_tuser  <= p.packet_kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pass_results_q.push_back(run_control_pass(p));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pass_results_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegBeepPeriod:   alarm_cfg.beep_period_ms   = val;
      RegHeartbeatOn:  alarm_cfg.heartbeat_on_ms  = val;
      RegHeartbeatOff: alarm_cfg.heartbeat_off_ms = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_timing(input logic [15:0] beep, input logic [15:0] on,
                             input logic [15:0] off);
    wait_idle();
    write_reg(RegBeepPeriod, beep);
    write_reg(RegHeartbeatOn, on);
    write_reg(RegHeartbeatOff, off);
  endtask

  // mostly link up, starts with fresh stamps, stops and button presses
  task automatic run_random(input int count, input int max_step);
    int          r;
    logic        link;
    logic        btn;
    logic [1:0]  kind;
    logic [31:0] stamp;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 4) clock_ms = $urandom;
      else if (r >= 12) clock_ms = clock_ms + $urandom_range(1, max_step);
      link = ($urandom_range(99) >= 7);
      btn  = ($urandom_range(99) < 5);
      r = $urandom_range(99);
      if (r < 68) kind = KIND_NONE;
      else if (r < 82) kind = KIND_START;
      else if (r < 92) kind = KIND_STOP;
      else kind = KindUnused;
      if (kind == KIND_START) begin
        if ($urandom_range(99) < 80)
          stamp = alarm_state.last_stamp + $urandom_range(1, 65536);
        else
          stamp = $urandom_range(alarm_state.last_stamp, 0);
      end else begin
        stamp = $urandom;
      end
      send_pass(pass_of(clock_ms, link, btn, kind, stamp));
    end
  endtask

  task automatic test_link_down();
    send_pass(pass_of(32'd10, 1'b0, 1'b1, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd20, 1'b0, 1'b0, KIND_START, 32'd100));
  endtask

  task automatic test_heartbeat();
    send_pass(pass_of(32'd30, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd950, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd999, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd1000, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd1010, 1'b1, 1'b0, KIND_STOP, 32'd0));
  endtask

  task automatic test_arm_and_beep();
    // start together with the button: the press is lost
    send_pass(pass_of(32'd1100, 1'b1, 1'b1, KIND_START, 32'd1));
    send_pass(pass_of(32'd1369, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd1370, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd1400, 1'b1, 1'b0, KIND_START, 32'd1));
    send_pass(pass_of(32'd1500, 1'b1, 1'b0, KIND_START, 32'd2));
    send_pass(pass_of(32'd1600, 1'b0, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd1770, 1'b1, 1'b0, KindUnused, 32'd9));
    send_pass(pass_of(32'd2040, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd2050, 1'b1, 1'b0, KIND_STOP, 32'd0));
    // beep phase survives the stop, so this toggle silences a silent buzzer
    send_pass(pass_of(32'd2100, 1'b1, 1'b0, KIND_START, 32'd3));
    send_pass(pass_of(32'd2370, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'd2400, 1'b1, 1'b1, KIND_NONE, 32'd0));
  endtask

  task automatic test_time_wrap();
    send_pass(pass_of(32'hFFFF_FF00, 1'b1, 1'b0, KIND_START, 32'd4));
    send_pass(pass_of(32'h0000_000E, 1'b1, 1'b0, KIND_NONE, 32'd0));
    send_pass(pass_of(32'h0000_0020, 1'b1, 1'b1, KIND_NONE, 32'd0));
  endtask

  task automatic test_backpressure();
    -> hold_rx;
    run_random(40, 300);
    wait_idle();
    run_random(20, 300);
  endtask

  // last, since nothing can arm once the newest stamp is at its ceiling
  task automatic test_stamp_ceiling();
    send_pass(pass_of(clock_ms + 32'd10, 1'b1, 1'b0, KIND_START, 32'h8000_0000));
    send_pass(pass_of(clock_ms + 32'd20, 1'b1, 1'b0, KIND_START, 32'hFFFF_FFFF));
    send_pass(pass_of(clock_ms + 32'd30, 1'b1, 1'b0, KIND_START, 32'hFFFF_FFFF));
    send_pass(pass_of(clock_ms + 32'd40, 1'b1, 1'b0, KIND_STOP, 32'h0000_0000));
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always begin
    @(hold_rx);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic check_field(input string name, input logic [2:0] want,
                             input logic [2:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0b, actual %0b", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    acc_result_t got;
    acc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = acc_result_t'(m_axis_tdata[4:0]);
      if (pass_results_q.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual %b",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pass_results_q.pop_front();
        check_field("red_led", {2'b00, want.red_led}, {2'b00, got.red_led});
        check_field("green_led", {2'b00, want.green_led}, {2'b00, got.green_led});
        check_field("buzzer_on", {2'b00, want.buzzer_on}, {2'b00, got.buzzer_on});
        check_field("report_stop", {2'b00, want.report_stop},
                    {2'b00, got.report_stop});
        check_field("request_reconnect", {2'b00, want.request_reconnect},
                    {2'b00, got.request_reconnect});
        check_field("padding", 3'b000, m_axis_tdata[7:5]);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    alarm_state   = '0;
    alarm_state.red_level     = 1'b1;
    alarm_cfg.beep_period_ms   = BeepPeriodRst;
    alarm_cfg.heartbeat_on_ms  = HeartbeatOnRst;
    alarm_cfg.heartbeat_off_ms = HeartbeatOffRst;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_link_down();
    test_heartbeat();
    test_arm_and_beep();
    test_time_wrap();

    load_timing(16'd1, 16'd1, 16'd1);
    run_random(280, 3);

    send_idle_pct = 88;
    recv_idle_pct = 9;
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(280, 40000);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_timing(16'($urandom_range(600, 1)), 16'($urandom_range(200, 1)),
                16'($urandom_range(900, 1)));
    write_reg(RegUnused, 16'($urandom));
    test_backpressure();
    run_random(250, 300);

    test_stamp_ceiling();
    wait_idle();

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: alarm_annunciator_control.f
rtl/acc_pkg.sv
rtl/acc_pass.sv
rtl/alarm_annunciator_control.sv
rtl/acc_checker.sv
tb/alarm_annunciator_control_tb.sv
